// ===== rtl/core/rbb_pkg.sv =====
// shared types and constants of the 5x5 rgb box blur
`default_nettype none

package rbb_pkg;

  // pixel and result field widths
  localparam int unsigned CHANNELS = 3;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned OCOL_W   = 11;

  // window and line store geometry
  localparam int unsigned KERNEL = 5;
  localparam int unsigned LINES  = 4;
  localparam int unsigned SLOT_W = 2;

  // column sum of five 8-bit values, window sum of 25
  localparam int unsigned CSUM_W = 11;
  localparam int unsigned WSUM_W = 13;

  // floor(x / 25) = (x * 5243) >> 17 for every x below 43690
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;

  // result queue
  localparam int unsigned MAX_RES     = 4;
  localparam int unsigned RES_CNT_W   = 3;
  localparam int unsigned RFIFO_DEPTH = 16;
  localparam int unsigned RFIFO_AW    = 4;
  localparam int unsigned RFIFO_CW    = 5;

  // frame size registers
  localparam int unsigned FW_W       = 12;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned MIN_WIDTH  = 5;
  localparam int unsigned MIN_HEIGHT = 5;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // channel 0 (blue) in the low byte
  typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic              last;
    logic [OCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
    pixel_t            pix;
  } result_t;

  // results of one pixel, handed to the queue in one cycle
  typedef struct packed {
    logic [RES_CNT_W-1:0]      num;
    result_t [MAX_RES-1:0]     ent;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbb_result_fifo.sv =====
// result queue taking up to four beats per cycle and giving one
`default_nettype none

module rbb_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbb_pkg::push_t   push_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rbb_pkg::result_t out_data_o
);
  import rbb_pkg::*;

  result_t              mem_q [RFIFO_DEPTH];
  logic [RFIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [RFIFO_CW-1:0]  cnt_q;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // write the pushed beats at consecutive slots, room is reserved upstream
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < push_i.num) begin
        mem_q[wr_ptr_q + RFIFO_AW'(k)] <= push_i.ent[k];
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RFIFO_AW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RFIFO_AW'(1);
      end
      cnt_q <= cnt_q + RFIFO_CW'(push_i.num) - RFIFO_CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_box_blur_5x5_top.sv =====
// top level of the streaming 5x5 rgb box blur
//
// Pixels enter in raster order on s_axis, one beat per clock; each interior pixel leaves as
// the per-channel floor mean of its 5x5 neighborhood, every other pixel unchanged, tagged
// with its row and column. A pixel is taken every cycle while the result queue has room for
// four more beats; its results reach the 16-beat queue and leave at one beat per clock
// unless stalled. A row end from row 2 on gives three beats and pixels of the last two rows
// give up to four, so there the input follows the output rate once the queue is full. The
// four line stores are one memory of MAX_WIDTH words of four pixels, read at the pixel's
// column on acceptance and rewritten the next cycle; its content is undefined after reset
// and needs no clearing pass. Configuration writes are taken at any time but belong in idle.
`default_nettype none

module rgb_box_blur_5x5_top #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  rbb_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [rbb_pkg::FH_W-1:0]  cfg_data_i,
  // pixel input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // blue_in, green_in, red_in
  // result output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,   // blue_out, green_out, red_out,
                                                    // out_row, out_col, zero pad
  output logic                      m_axis_tlast    // last_of_run
);
  import rbb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  typedef struct packed {
    pixel_t           pix;
    logic [ROW_W-1:0] row;
    logic [CW-1:0]    col;
    logic             emit_ctr;
    logic             emit_end;
    logic             emit_raw;
    logic             smooth;
  } item_t;

  // configuration registers
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the frame size
  logic [WW-1:0]   fw_ext, w_eff;
  logic [FH_W-1:0] h_eff;

  assign fw_ext = WW'(fw_q);

  always_comb begin
    if (fw_ext < WW'(MIN_WIDTH)) begin
      w_eff = WW'(MIN_WIDTH);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (fh_q < FH_W'(MIN_HEIGHT)) begin
      h_eff = FH_W'(MIN_HEIGHT);
    end else if (fh_q > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
  end

  // position counters and result flags of the incoming pixel
  logic [CW-1:0]        col_q, col_d, cur_col;
  logic [ROW_W-1:0]     row_q, row_d, cur_row;
  logic [WW-1:0]        col_c, col_inc;
  logic [FH_W-1:0]      row_c, row_inc;
  logic                 beyond;
  item_t                in_item;
  logic [RES_CNT_W-1:0] n_res;
  logic                 in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    beyond  = (WW'(col_q) >= w_eff) || (FH_W'(row_q) >= h_eff);
    cur_col = beyond ? '0 : col_q;
    cur_row = beyond ? '0 : row_q;
    col_c   = WW'(cur_col);
    row_c   = FH_W'(cur_row);

    in_item.pix      = s_axis_tdata;
    in_item.row      = cur_row;
    in_item.col      = cur_col;
    in_item.emit_ctr = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
    in_item.smooth   = (cur_row >= ROW_W'(4)) && (cur_col >= CW'(4));
    in_item.emit_end = (cur_row >= ROW_W'(2)) && (col_c == w_eff - WW'(1));
    in_item.emit_raw = (row_c >= h_eff - FH_W'(2));
    n_res = RES_CNT_W'(in_item.emit_ctr) + RES_CNT_W'({in_item.emit_end, 1'b0})
          + RES_CNT_W'(in_item.emit_raw);

    // advance in raster order, wrap at frame end
    col_inc = col_c + WW'(1);
    row_inc = row_c + FH_W'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // queue room: beats in the queue plus beats promised by pixels in flight
  logic [RFIFO_CW-1:0] occ_q;

  assign s_axis_tready = (occ_q <= RFIFO_CW'(RFIFO_DEPTH - MAX_RES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + (in_fire ? RFIFO_CW'(n_res) : '0) - RFIFO_CW'(out_fire);
    end
  end

  // line store: one word per column, slot (row mod 4) holds that row's pixel.
  // a column is read again only a full row later, after its write-back is done
  pixel_t [LINES-1:0] line_mem [MAX_WIDTH];
  pixel_t [LINES-1:0] rd_q, wr_word;
  logic               s1_vld_q;
  item_t              s1_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= line_mem[cur_col];
    end
    if (s1_vld_q) begin
      line_mem[s1_q.col] <= wr_word;
    end
  end

  // stage 1: new window column, rows r-4 .. r
  logic [SLOT_W-1:0]                     s1_slot;
  pixel_t [KERNEL-1:0]                   col_pix;
  logic [CHANNELS-1:0][CSUM_W-1:0]       csum_new;

  assign s1_slot = s1_q.row[SLOT_W-1:0];

  always_comb begin
    col_pix[KERNEL-1] = s1_q.pix;
    for (int k = 0; k < LINES; k++) begin
      col_pix[k] = rd_q[s1_slot + SLOT_W'(k)];
    end
    wr_word          = rd_q;
    wr_word[s1_slot] = s1_q.pix;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      csum_new[ch] = '0;
      for (int k = 0; k < KERNEL; k++) begin
        csum_new[ch] = csum_new[ch] + CSUM_W'(col_pix[k][ch]);
      end
    end
  end

  // window: column sums and the center row, oldest column at index 0
  logic [KERNEL-1:0][CHANNELS-1:0][CSUM_W-1:0] csum_q;
  pixel_t [KERNEL-1:0]                         mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= '0;
      mid_q  <= '0;
    end else if (s1_vld_q) begin
      for (int j = 0; j < KERNEL - 1; j++) begin
        csum_q[j] <= csum_q[j+1];
        mid_q[j]  <= mid_q[j+1];
      end
      csum_q[KERNEL-1] <= csum_new;
      mid_q[KERNEL-1]  <= col_pix[2];
    end
  end

  // stage 2: window sum and center row taps
  logic                            s2_vld_q, s3_vld_q;
  item_t                           s2_q, s3_q;
  logic [CHANNELS-1:0][WSUM_W-1:0] wsum, wsum_q;
  pixel_t [2:0]                    tap_q;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wsum[ch] = '0;
      for (int j = 0; j < KERNEL; j++) begin
        wsum[ch] = wsum[ch] + WSUM_W'(csum_q[j][ch]);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_fire;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item;
    end
    s2_q   <= s1_q;
    s3_q   <= s2_q;
    wsum_q <= wsum;
    tap_q  <= {mid_q[4], mid_q[3], mid_q[2]};
  end

  // stage 3: divide by 25 and form the result beats
  logic [CHANNELS-1:0][WSUM_W+RECIP_W-1:0] prod;
  pixel_t                                  mean;
  result_t                                 r_ctr, r_pen, r_lst, r_raw;
  logic [RES_CNT_W-1:0]                    s3_num;
  push_t                                   push;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod[ch] = (WSUM_W+RECIP_W)'(wsum_q[ch]) * (WSUM_W+RECIP_W)'(RECIP_25);
      mean[ch] = prod[ch][RECIP_SHIFT +: PIX_W];
    end

    r_ctr.pix  = s3_q.smooth ? mean : tap_q[0];
    r_ctr.row  = s3_q.row - ROW_W'(2);
    r_ctr.col  = OCOL_W'(s3_q.col - CW'(2));
    r_ctr.last = 1'b0;
    // row end: the two right border pixels of row r-2
    r_pen.pix  = tap_q[1];
    r_pen.row  = s3_q.row - ROW_W'(2);
    r_pen.col  = OCOL_W'(s3_q.col - CW'(1));
    r_pen.last = 1'b0;
    r_lst.pix  = tap_q[2];
    r_lst.row  = s3_q.row - ROW_W'(2);
    r_lst.col  = OCOL_W'(s3_q.col);
    r_lst.last = 1'b0;
    // bottom border rows pass the input itself
    r_raw.pix  = s3_q.pix;
    r_raw.row  = s3_q.row;
    r_raw.col  = OCOL_W'(s3_q.col);
    r_raw.last = 1'b0;

    s3_num = RES_CNT_W'(s3_q.emit_ctr) + RES_CNT_W'({s3_q.emit_end, 1'b0})
           + RES_CNT_W'(s3_q.emit_raw);

    // a row end implies a center result, so the order packs as below
    push.ent[0] = s3_q.emit_ctr ? r_ctr : r_raw;
    push.ent[1] = s3_q.emit_end ? r_pen : r_raw;
    push.ent[2] = r_lst;
    push.ent[3] = r_raw;
    for (int k = 0; k < MAX_RES; k++) begin
      push.ent[k].last = (RES_CNT_W'(k) == s3_num - RES_CNT_W'(1));
    end
    push.num = s3_vld_q ? s3_num : '0;
  end

  // result queue and output packing
  result_t head;

  rbb_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (head)
  );

  assign m_axis_tdata = {1'b0, head.col, head.row, head.pix};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/rbb_checker.sv =====
// port-level checks of the 5x5 rgb box blur and their bind
`default_nettype none

module rbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import rbb_pkg::*;

  logic             in_beat, out_beat;
  logic             in_seen_q;
  logic             open_q;
  logic [ROW_W-1:0] row_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // track whether any pixel came in and whether a run is still open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seen_q <= 1'b0;
      open_q    <= 1'b0;
    end else begin
      if (in_beat) begin
        in_seen_q <= 1'b1;
      end
      if (out_beat) begin
        open_q <= !m_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_beat) begin
      row_q <= m_axis_tdata[35:24];
    end
  end

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // reset empties the result queue, seen from the next edge on
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // no result before the first pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> in_seen_q)
    else $error("result without any input pixel");

  // within one run the rows never go back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && open_q |-> m_axis_tdata[35:24] >= row_q)
    else $error("result rows out of order within a run");

endmodule

bind rgb_box_blur_5x5_top rbb_checker u_rbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
